/* rtl/diagonal_majority_morphology_defines.svh */
// assertion helpers used by dmm_ctrl
`ifndef DIAGONAL_MAJORITY_MORPHOLOGY_DEFINES_SVH
`define DIAGONAL_MAJORITY_MORPHOLOGY_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define DMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dmm_pkg.sv */
// ----------------------------------------------------------------------------
// dmm_pkg
// shared types and constants of the diagonal majority morphology filter
// ----------------------------------------------------------------------------
package dmm_pkg;

    localparam logic [23:0] WHITE_PIX = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_RADIUS = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    // configuration reset values
    localparam logic        MODE_RST   = 1'b0;
    localparam logic [3:0]  RADIUS_RST = 4'd11;
    localparam logic [10:0] WIDTH_RST  = 11'd640;
    localparam logic [10:0] HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic accept;
        logic start_vote;
        logic vote_step;
        logic load_out;
    } dmm_cmd_t;

    typedef struct packed {
        logic emit_ok;
        logic vote_last;
        logic out_free;
    } dmm_status_t;

endpackage

/* rtl/dmm_ctrl.sv */
// ----------------------------------------------------------------------------
// dmm_ctrl
// sequencer: accept, emit check, vote loop, flush and output load
// ----------------------------------------------------------------------------
`include "diagonal_majority_morphology_defines.svh"

module dmm_ctrl
    import dmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  dmm_status_t status,
    output dmm_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_VOTE  = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_LOAD  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.accept     = (state_reg == S_IDLE) && in_valid;
        cmd.start_vote = (state_reg == S_CHECK) && status.emit_ok;
        cmd.vote_step  = (state_reg == S_VOTE);
        cmd.load_out   = (state_reg == S_LOAD) && status.out_free;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = status.emit_ok ? S_VOTE : S_IDLE;
            end
            S_VOTE:
            begin
                if (status.vote_last)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `DMM_ASSERT_NEXT(a_accept_then_check, cmd.accept, state_reg == S_CHECK, "accept not followed by check")
    `DMM_ASSERT_NOW(a_load_needs_room, cmd.load_out, status.out_free, "output load while register busy")
    `DMM_ASSERT_NEXT(a_flush_then_load, state_reg == S_FLUSH, state_reg == S_LOAD, "flush not followed by load")

endmodule

/* rtl/dmm_datapath.sv */
// ----------------------------------------------------------------------------
// dmm_datapath
// config registers, line ring memories, counters, vote accumulator, output
// ----------------------------------------------------------------------------
module dmm_datapath
    import dmm_pkg::*;
#(
    parameter int MAX_RADIUS = 11,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [10:0]  cfg_wdata,
    input  logic [23:0]  pixel_color,
    input  logic         drain,
    input  dmm_cmd_t     cmd,
    output dmm_status_t  status,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [23:0]  out_color,
    output logic         frame_last
);

    localparam int RING  = 2 * MAX_RADIUS + 2;
    localparam int SW    = $clog2(RING);
    localparam int CW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int RADW  = $clog2(MAX_RADIUS + 1);
    localparam int DEPTH = RING * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int TW    = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
    localparam int VW    = $clog2(4 * MAX_RADIUS + 2);
    localparam int CMPW  = (TW > PW ? TW : PW) + 1;

    // configuration
    logic        mode_reg;
    logic [3:0]  radius_reg;
    logic [10:0] fw_reg;
    logic [10:0] fh_reg;
    logic        restart;

    logic [CW-1:0]   eff_w;
    logic [HW-1:0]   eff_h;
    logic [RADW-1:0] eff_r;

    always_comb
    begin
        if (fw_reg == 11'd0)
            eff_w = CW'(1);
        else if (int'(fw_reg) > MAX_WIDTH)
            eff_w = CW'(MAX_WIDTH);
        else
            eff_w = CW'(fw_reg);
        if (fh_reg == 11'd0)
            eff_h = HW'(1);
        else if (int'(fh_reg) > MAX_HEIGHT)
            eff_h = HW'(MAX_HEIGHT);
        else
            eff_h = HW'(fh_reg);
        if (int'(radius_reg) > MAX_RADIUS)
            eff_r = RADW'(MAX_RADIUS);
        else
            eff_r = RADW'(radius_reg);
    end

    assign restart = cfg_we && (cfg_index != CFG_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_RST;
            radius_reg <= RADIUS_RST;
            fw_reg     <= WIDTH_RST;
            fh_reg     <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODE:   mode_reg   <= cfg_wdata[0];
                CFG_RADIUS: radius_reg <= cfg_wdata[3:0];
                CFG_WIDTH:  fw_reg     <= cfg_wdata;
                CFG_HEIGHT: fh_reg     <= cfg_wdata;
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    // derived geometry, one product per register
    logic [PW-1:0] lag_reg;
    logic [TW-1:0] total_reg;

    always_ff @(posedge clk)
    begin
        lag_reg   <= PW'(int'(eff_r) * int'(eff_w) + int'(eff_r));
        total_reg <= TW'(int'(eff_h) * int'(eff_w));
    end

    // stream counters
    logic [CW-1:0] in_col_reg, out_col_reg;
    logic [HW-1:0] in_row_reg, out_row_reg;
    logic [SW-1:0] in_slot_reg, out_slot_reg;
    logic [PW-1:0] pending_reg;
    logic [TW-1:0] out_idx_reg;

    logic wr_en;
    assign wr_en = cmd.accept && !drain;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_idx_reg  <= '0;
            pending_reg  <= '0;
        end
        else if (restart)
        begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_slot_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_slot_reg <= '0;
            out_idx_reg  <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                pending_reg <= pending_reg + PW'(1);
                if (in_col_reg + CW'(1) >= eff_w)
                begin
                    in_col_reg  <= '0;
                    in_slot_reg <= (int'(in_slot_reg) == RING - 1) ? '0
                                                                   : in_slot_reg + SW'(1);
                    in_row_reg  <= (in_row_reg + HW'(1) >= eff_h) ? '0
                                                                 : in_row_reg + HW'(1);
                end
                else
                begin
                    in_col_reg <= in_col_reg + CW'(1);
                end
            end
            if (cmd.load_out)
            begin
                pending_reg <= pending_reg - PW'(1);
                out_idx_reg <= out_idx_reg + TW'(1);
                if (out_col_reg + CW'(1) >= eff_w)
                begin
                    out_col_reg  <= '0;
                    out_slot_reg <= (int'(out_slot_reg) == RING - 1) ? '0
                                                                     : out_slot_reg + SW'(1);
                    if (out_row_reg + HW'(1) >= eff_h)
                    begin
                        out_row_reg <= '0;
                        out_idx_reg <= '0;
                    end
                    else
                    begin
                        out_row_reg <= out_row_reg + HW'(1);
                    end
                end
                else
                begin
                    out_col_reg <= out_col_reg + CW'(1);
                end
            end
        end
    end

    // emit decision
    logic [CMPW-1:0] remaining;
    assign remaining = CMPW'(total_reg) - CMPW'(out_idx_reg);
    assign status.emit_ok = (pending_reg != '0)
                         && ((pending_reg > lag_reg) || (CMPW'(pending_reg) >= remaining));

    // vote sequencing
    logic [RADW:0]   a_reg;
    logic [2:0]      tap_reg;
    logic [VW-1:0]   nb_reg, nw_reg;
    logic            rd_pend_reg;
    logic            active, oob, need_rd, last_tap;
    logic [SW-1:0]   up_slot, dn_slot, rd_slot;
    logic [CW-1:0]   rd_col;
    logic [AW-1:0]   rd_addr, wr_addr, ctr_addr;
    logic            white_q;
    logic [23:0]     color_q;

    assign active   = (int'(a_reg) <= int'(eff_r)) && (a_reg != '0);
    assign oob      = (int'(out_row_reg) < int'(a_reg)) || (int'(out_col_reg) < int'(a_reg))
                   || (int'(out_row_reg) + int'(a_reg) >= int'(eff_h))
                   || (int'(out_col_reg) + int'(a_reg) >= int'(eff_w));
    assign last_tap = (tap_reg == 3'd4);
    assign need_rd  = (tap_reg != 3'd0) || (a_reg == (RADW+1)'(1));
    assign status.vote_last = !active || ((int'(a_reg) == int'(eff_r)) && (oob || last_tap));

    always_comb
    begin
        up_slot = (int'(out_slot_reg) >= int'(a_reg))
                ? SW'(int'(out_slot_reg) - int'(a_reg))
                : SW'(int'(out_slot_reg) + RING - int'(a_reg));
        dn_slot = (int'(out_slot_reg) + int'(a_reg) >= RING)
                ? SW'(int'(out_slot_reg) + int'(a_reg) - RING)
                : SW'(int'(out_slot_reg) + int'(a_reg));
        case (tap_reg)
            3'd1:
            begin
                rd_slot = up_slot;
                rd_col  = CW'(int'(out_col_reg) - int'(a_reg));
            end
            3'd2:
            begin
                rd_slot = up_slot;
                rd_col  = CW'(int'(out_col_reg) + int'(a_reg));
            end
            3'd3:
            begin
                rd_slot = dn_slot;
                rd_col  = CW'(int'(out_col_reg) - int'(a_reg));
            end
            3'd4:
            begin
                rd_slot = dn_slot;
                rd_col  = CW'(int'(out_col_reg) + int'(a_reg));
            end
            default:
            begin
                rd_slot = out_slot_reg;
                rd_col  = out_col_reg;
            end
        endcase
    end

    assign rd_addr  = AW'(int'(rd_slot) * MAX_WIDTH + int'(rd_col));
    assign wr_addr  = AW'(int'(in_slot_reg) * MAX_WIDTH + int'(in_col_reg));
    assign ctr_addr = AW'(int'(out_slot_reg) * MAX_WIDTH + int'(out_col_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg <= 1'b0;
            a_reg       <= '0;
            tap_reg     <= '0;
        end
        else if (cmd.start_vote)
        begin
            rd_pend_reg <= 1'b0;
            a_reg       <= (RADW+1)'(1);
            tap_reg     <= '0;
        end
        else
        begin
            rd_pend_reg <= cmd.vote_step && active && !oob && need_rd;
            if (cmd.vote_step && active)
            begin
                if (oob || last_tap)
                begin
                    a_reg   <= a_reg + (RADW+1)'(1);
                    tap_reg <= '0;
                end
                else
                begin
                    tap_reg <= tap_reg + 3'd1;
                end
            end
        end
    end

    // vote counts
    always_ff @(posedge clk)
    begin
        if (cmd.start_vote)
        begin
            nb_reg <= '0;
            nw_reg <= '0;
        end
        else
        begin
            nb_reg <= nb_reg + VW'(cmd.vote_step && active && oob)
                             + VW'(rd_pend_reg && !white_q);
            nw_reg <= nw_reg + VW'(rd_pend_reg && white_q);
        end
    end

    // line ring memories
    logic            white_mem [DEPTH];
    logic [23:0]     color_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            white_mem[wr_addr] <= (pixel_color == WHITE_PIX);
            color_mem[wr_addr] <= pixel_color;
        end
        white_q <= white_mem[rd_addr];
        color_q <= color_mem[ctr_addr];
    end

    // output register
    logic        out_valid_reg;
    logic [23:0] out_color_reg;
    logic        frame_last_reg;
    logic [23:0] result;

    always_comb
    begin
        result = color_q;
        if (!mode_reg)
        begin
            if (nb_reg > nw_reg)
                result = '0;
        end
        else
        begin
            if (nw_reg > nb_reg)
                result = WHITE_PIX;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_color_reg  <= result;
            frame_last_reg <= (out_row_reg == eff_h - HW'(1))
                           && (out_col_reg == eff_w - CW'(1));
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_color  = out_color_reg;
    assign frame_last = frame_last_reg;

endmodule

/* rtl/diagonal_majority_morphology.sv */
// timing: each input transfer passes the emit check; a result, if due, comes after the vote
// loop, whose length is set by the single read port of the white line memory (one read a cycle)
// flow: one item in flight; next input taken as soon as the result is registered, or once
// the emit check finds no result due; output stalls hold the result and the next input back
// reset: rst_n clears counters, sequencer and output valid at once; line
// memories are not cleared and hold only written pixels when read
// ----------------------------------------------------------------------------
// diagonal_majority_morphology
// binary majority vote erode or dilate over an x-shaped window, raster stream
// ----------------------------------------------------------------------------
module diagonal_majority_morphology
    import dmm_pkg::*;
#(
    parameter int MAX_RADIUS = 11,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_wdata,
    // input pixel transfer
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [23:0] pixel_color,
    input  logic        drain,
    // result transfer
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] out_color,
    output logic        frame_last
);

    // command and status between sequencer and datapath
    dmm_cmd_t    cmd;
    dmm_status_t status;

    // sequencer: accept, emit check, neighbor read loop, output load
    dmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: ring of line memories, counters, vote counts, output register
    dmm_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .pixel_color (pixel_color),
        .drain       (drain),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_color   (out_color),
        .frame_last  (frame_last)
    );

endmodule

/* tb/tb_diagonal_majority_morphology.sv */
// ----------------------------------------------------------------------------
// tb_diagonal_majority_morphology
// streams raster frames of white and colored pixels through the diagonal
// majority filter under many geometries, radii and both modes, predicts each
// filtered pixel and checks every result transfer in order
// ----------------------------------------------------------------------------
module tb_diagonal_majority_morphology;
    import dmm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_ROWS  = 24;        // 2*max radius + 2 rows of history
    localparam int LINE_MAX   = 1024;
    localparam int RADIUS_MAX = 11;
    localparam int SETTLE     = 80;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int ITEM_TARGET = 1750;

    // predictor of filtered pixels plus the store of pixels still due
    class dmm_scoreboard;
        typedef struct packed {
            logic        last;
            logic [23:0] color;
        } filtered_t;

        bit          white_ring[RING_ROWS][LINE_MAX];
        logic [23:0] color_ring[RING_ROWS][LINE_MAX];
        int unsigned mode, radius, wid_reg, hgt_reg;
        int unsigned in_row, in_col, out_row, out_col, in_slot, out_slot, pending;
        filtered_t   due[$];
        int          errors;

        function new();
            mode = MODE_RST;
            radius = RADIUS_RST;
            wid_reg = WIDTH_RST;
            hgt_reg = HEIGHT_RST;
            errors = 0;
            restart_stream();
        endfunction

        function void restart_stream();
            in_row = 0; in_col = 0; out_row = 0; out_col = 0;
            in_slot = 0; out_slot = 0; pending = 0;
        endfunction

        function int unsigned eff_w();
            if (wid_reg == 0) return 1;
            return (wid_reg > LINE_MAX) ? LINE_MAX : wid_reg;
        endfunction

        function int unsigned eff_h();
            if (hgt_reg == 0) return 1;
            return (hgt_reg > LINE_MAX) ? LINE_MAX : hgt_reg;
        endfunction

        function int unsigned eff_r();
            return (radius > RADIUS_MAX) ? RADIUS_MAX : radius;
        endfunction

        function void write_reg(logic [1:0] idx, logic [10:0] data);
            case (idx)
                CFG_MODE:   mode = data[0];
                CFG_RADIUS: begin radius = data[3:0]; restart_stream(); end
                CFG_WIDTH:  begin wid_reg = data; restart_stream(); end
                CFG_HEIGHT: begin hgt_reg = data; restart_stream(); end
                default: ;
            endcase
        endfunction

        // oldest pending pixel has all neighbors, or its frame is complete
        function bit ready_to_emit();
            int unsigned w, r;
            w = eff_w();
            r = eff_r();
            if (pending == 0) return 0;
            return (pending > r * w + r) || (pending >= (eff_h() - out_row) * w - out_col);
        endfunction

        function void note_input(logic [23:0] px, logic drn);
            int unsigned w, h, r, nb, nw, up, dn, v, n;
            logic [23:0] c;
            w = eff_w();
            h = eff_h();
            r = eff_r();
            nb = 0;
            nw = 0;
            if (!drn) begin
                color_ring[in_slot][in_col] = px;
                white_ring[in_slot][in_col] = (px == WHITE_PIX);
                pending++;
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_slot = (in_slot + 1) % RING_ROWS;
                    in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
                end
            end
            if (!ready_to_emit()) return;
            for (int unsigned a = 1; a <= r; a++) begin
                // an offset off the frame edge is one black vote
                if (out_row < a || out_col < a || out_row + a >= h || out_col + a >= w) begin
                    nb++;
                    continue;
                end
                up = (out_slot + RING_ROWS - a) % RING_ROWS;
                dn = (out_slot + a) % RING_ROWS;
                v = white_ring[up][out_col - a] + white_ring[up][out_col + a]
                  + white_ring[dn][out_col - a] + white_ring[dn][out_col + a];
                n = 4;
                if (a == 1) begin
                    v += white_ring[out_slot][out_col];
                    n++;
                end
                nw += v;
                nb += n - v;
            end
            c = color_ring[out_slot][out_col];
            if (mode == 0 && nb > nw) c = '0;
            if (mode == 1 && nw > nb) c = WHITE_PIX;
            due.push_back('{last: (out_row == h - 1 && out_col == w - 1), color: c});
            pending--;
            out_col++;
            if (out_col >= w) begin
                out_col = 0;
                out_slot = (out_slot + 1) % RING_ROWS;
                out_row = (out_row + 1 >= h) ? 0 : out_row + 1;
            end
        endfunction

        function void check_result(logic [23:0] color, logic last);
            filtered_t exp_px;
            if (due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result color %h last %b", $realtime, color, last);
                return;
            end
            exp_px = due.pop_front();
            if (color !== exp_px.color) begin
                errors++;
                $display("%0t: out_color expected %h actual %h",
                         $realtime, exp_px.color, color);
            end
            if (last !== exp_px.last) begin
                errors++;
                $display("%0t: frame_last expected %b actual %b",
                         $realtime, exp_px.last, last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [23:0] pixel_color;
    logic        drain;
    logic        out_valid;
    logic        out_stall;
    logic [23:0] out_color;
    logic        frame_last;

    dmm_scoreboard sb;
    int          idle_pct;      // sender idles this share of cycles
    int          stall_pct;     // receiver stalls this share of cycles
    int          hold_cycles;   // long receiver hold-off, counted down below
    int          cycles;
    int          pixels_sent;

    diagonal_majority_morphology DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pixel_color (pixel_color),
        .drain       (drain),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_color   (out_color),
        .frame_last  (frame_last)
    );

    always #1 clk = ~clk;

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_diagonal_majority_morphology: done, errors");
            $finish;
        end
    end

    // result side: check each transfer, then pick the stall for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_color, frame_last);
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
        out_stall <= (hold_cycles > 1) || ($urandom_range(99) < stall_pct);
    end

    // half pure white so votes swing both ways, the rest near-white or random
    function automatic logic [23:0] rand_pixel();
        case ($urandom_range(3))
            0, 1:    return WHITE_PIX;
            2:       return 24'($urandom);
            default: return WHITE_PIX ^ (24'd1 << $urandom_range(23));
        endcase
    endfunction

    // one input transfer, with random idle cycles ahead of it
    task automatic send_item(logic [23:0] px, logic drn);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        pixel_color <= px;
        drain       <= drn;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(px, drn);
        if (!drn)
            pixels_sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [10:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    // all results in, then the block's worst latency before touching registers
    task automatic settle();
        in_valid <= 1'b0;
        cfg_we   <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // stray upper bits on mode and radius writes must be ignored
    task automatic configure(int m, int r, int w, int h);
        write_reg(CFG_MODE, {10'($urandom), 1'(m)});
        write_reg(CFG_RADIUS, {7'($urandom), 4'(r)});
        write_reg(CFG_WIDTH, 11'(w));
        write_reg(CFG_HEIGHT, 11'(h));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // npix pixels with sparse drain noise, then drains while they still emit
    task automatic stream_pixels(int npix);
        for (int i = 0; i < npix; i++)
        begin
            if ($urandom_range(99) < 4)
                send_item(24'($urandom), 1'b1);
            send_item(rand_pixel(), 1'b0);
        end
        while (sb.ready_to_emit())
            send_item(24'($urandom), 1'b1);
    endtask

    task automatic set_idling(int sel);
        case (sel % 4)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 55; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 55; end
            default: begin idle_pct = 17; stall_pct = 17; end
        endcase
    endtask

    initial
    begin
        int w, h, r, ph;
        logic [23:0] pattern[12];

        clk = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_wdata = '0;
        in_valid = 1'b0;
        pixel_color = '0;
        drain = 1'b0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        hold_cycles = 0;
        cycles = 0;
        pixels_sent = 0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a 4x3 frame of extremes under both modes with radius 1
        pattern = '{WHITE_PIX, 24'h000000, WHITE_PIX, 24'hFFFFFE,
                    WHITE_PIX, WHITE_PIX, 24'h7FFFFF, WHITE_PIX,
                    24'hFEFFFF, WHITE_PIX, WHITE_PIX, 24'h123456};
        for (int m = 0; m < 2; m++)
        begin
            configure(m, 1, 4, 3);
            foreach (pattern[i])
                send_item(pattern[i], 1'b0);
            send_item(24'hFFFFFF, 1'b1);
            while (sb.ready_to_emit())
                send_item(24'h0, 1'b1);
            settle();
        end

        // geometry extremes: oversized and zero sizes, pass-through and big radius
        configure(1, 0, 2047, 2);
        stream_pixels(40);
        settle();
        configure(0, 15, 0, 0);
        stream_pixels(6);
        settle();
        configure(1, 2, 5, 2047);
        stream_pixels(60);
        settle();
        configure(0, 3, 1024, 1);
        stream_pixels(30);
        settle();

        // full radius on a larger frame while the receiver holds off for a while
        set_idling(1);
        configure(0, 11, 23, 23);
        hold_cycles = 400;
        stream_pixels(23 * 23);
        settle();

        // random small frames, one to three per setting
        ph = 0;
        while (pixels_sent < ITEM_TARGET)
        begin
            set_idling(ph);
            r = $urandom_range(0, 15);
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            configure($urandom_range(1), r, w, h);
            stream_pixels(w * h * $urandom_range(1, 3));
            settle();
            ph++;
        end

        if (sb.errors == 0)
            $display("tb_diagonal_majority_morphology: done, clean");
        else
            $display("tb_diagonal_majority_morphology: done, errors");
        $finish;
    end

endmodule
